@@ design/pc1_pkg.sv @@
// Shared types and constants of the PC1 stream decryption block.
package pc1_pkg;

    // Round arithmetic constants
    localparam logic [15:0] MUL_A       = 16'h4e35;
    localparam logic [15:0] MUL_B       = 16'h015a;
    localparam logic [7:0]  LETTER_BIAS = 8'h25;

    // Key organisation: 32 bytes held as 16 words, four 64-bit registers
    localparam int ROUNDS     = 16;
    localparam int ROUND_W    = $clog2(ROUNDS);
    localparam int KEY_REGS   = 4;
    localparam int WORDS_PER_REG = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    // Back end sequencer states
    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    // Queued cipher byte as seen by the back end
    typedef struct packed {
        logic       valid;
        logic [7:0] cipher;
    } t_cipher_item;

endpackage

@@ design/pc1_front.sv @@
// Front end: accepts letter pairs, forms the cipher byte and queues it.
module pc1_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_high_letter,
    input  logic [7:0]            i_low_letter,
    input  logic                  i_pop,
    output pc1_pkg::t_cipher_item o_item
);
    import pc1_pkg::*;

    logic [7:0] r_data [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    logic       push;
    logic [7:0] hi_nib;
    logic [7:0] lo_nib;
    logic [7:0] cipher;

    // Letter to nibble, wrapping for letters outside the alphabet
    assign hi_nib = i_high_letter - LETTER_BIAS;
    assign lo_nib = i_low_letter - LETTER_BIAS;
    assign cipher = {hi_nib[3:0], 4'b0000} + lo_nib;

    assign o_in_stall    = (r_count == 2'd2);
    assign push          = i_in_valid && !o_in_stall;
    assign o_item.valid  = (r_count != 2'd0);
    assign o_item.cipher = r_data[r_rptr];

    // Two-entry queue towards the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_data[r_wptr] <= cipher;
                r_wptr         <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_pop};
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("pop from empty queue");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

@@ design/pc1_back.sv @@
// Back end: sixteen keystream rounds per byte, key update and result register.
module pc1_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pc1_pkg::t_cipher_item        i_item,
    output logic                         o_pop,
    input  logic                         i_cfg_valid,
    input  logic [pc1_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                  i_cfg_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_plain_byte
);
    import pc1_pkg::*;

    t_state               r_state,  n_state;
    logic [ROUND_W-1:0]   r_round,  n_round;
    logic [15:0]          r_cs,     n_cs;
    logic [15:0]          r_mix,    n_mix;
    logic [15:0]          r_w,      n_w;
    logic [15:0]          r_acc,    n_acc;
    logic [7:0]           r_cipher, n_cipher;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out,    n_out;
    logic [63:0]          r_kreg [KEY_REGS];
    logic [63:0]          n_kreg [KEY_REGS];
    logic [15:0]          r_key  [ROUNDS];
    logic [15:0]          n_key  [ROUNDS];

    logic [15:0] k;
    logic [15:0] kb;
    logic [15:0] cs_rnd;
    logic [15:0] w_rnd;
    logic [15:0] acc_rnd;
    logic [7:0]  plain;
    logic        fin;

    // One round on the word at the head of the rotating key
    always_comb begin
        k       = (r_round == '0) ? r_key[0] : (r_w ^ r_key[0]);
        kb      = k * MUL_B;
        cs_rnd  = (r_cs + {{(16-ROUND_W){1'b0}}, r_round}) * MUL_A + kb + r_mix;
        w_rnd   = k * MUL_A + 16'd1;
        acc_rnd = ((r_round == '0) ? 16'd0 : r_acc) ^ w_rnd ^ cs_rnd;
        plain   = r_cipher ^ acc_rnd[15:8] ^ acc_rnd[7:0];
    end

    assign fin = (r_state == S_RUN) && (r_round == LAST_ROUND) &&
                 (!r_out_valid || !i_out_stall);

    // Sequencer, config writes and result register
    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_cs        = r_cs;
        n_mix       = r_mix;
        n_w         = r_w;
        n_acc       = r_acc;
        n_cipher    = r_cipher;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_kreg      = r_kreg;
        n_key       = r_key;
        o_pop       = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Key write reloads the whole working key
        if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(KEY_REGS))) begin
            n_kreg[i_cfg_index[1:0]] = i_cfg_data;
            for (int j = 0; j < ROUNDS; j++) begin
                n_key[j] = n_kreg[j / WORDS_PER_REG][63 - 16 * (j % WORDS_PER_REG) -: 16];
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    o_pop    = 1'b1;
                    n_cipher = i_item.cipher;
                    n_round  = '0;
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                if (r_round != LAST_ROUND) begin
                    n_cs    = cs_rnd;
                    n_mix   = kb;
                    n_w     = w_rnd;
                    n_acc   = acc_rnd;
                    n_round = r_round + 1'b1;
                    for (int j = 0; j < ROUNDS; j++) begin
                        n_key[j] = r_key[(j + 1) % ROUNDS];
                    end
                end else if (fin) begin
                    n_cs        = cs_rnd;
                    n_mix       = kb;
                    n_out       = plain;
                    n_out_valid = 1'b1;
                    n_round     = '0;
                    // Final rotation restores word order; fold plaintext in
                    for (int j = 0; j < ROUNDS; j++) begin
                        n_key[j] = r_key[(j + 1) % ROUNDS] ^ {plain, plain};
                    end
                    if (i_item.valid) begin
                        o_pop    = 1'b1;
                        n_cipher = i_item.cipher;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_cs        <= 16'd0;
            r_mix       <= 16'd0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < KEY_REGS; j++) begin
                r_kreg[j] <= 64'd0;
            end
            for (int j = 0; j < ROUNDS; j++) begin
                r_key[j] <= 16'd0;
            end
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_cs        <= n_cs;
            r_mix       <= n_mix;
            r_out_valid <= n_out_valid;
            r_kreg      <= n_kreg;
            r_key       <= n_key;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_acc    <= n_acc;
        r_cipher <= n_cipher;
        r_out    <= n_out;
    end

    assign o_out_valid  = r_out_valid;
    assign o_plain_byte = r_out;

`ifndef SYNTH
    a_idle_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_round == '0))
        else $error("round counter not at zero while idle");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_item.valid)
        else $error("pop without queued item");
    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> (r_out_valid && r_round == '0))
        else $error("finished byte did not reach result register");
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RUN) && (r_round == LAST_ROUND) && !fin) |=>
        ($stable(r_cs) && $stable(r_mix) && r_round == LAST_ROUND))
        else $error("round state moved while result register blocked");
`endif

endmodule

@@ design/pc1_stream_decrypt_256_unit.sv @@
// Top level of the PC1 256-bit key stream decryption block.
//
// Input channel: i_in_valid / o_in_stall carry one item, a pair of cipher
// letters; it is taken at a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry one plaintext byte per
// input item, in order. The result register holds its byte while stalled.
// Config channel: i_cfg_valid / o_cfg_ready write one of four 64-bit key
// registers (index 0..3, other indexes ignored); any key write reloads the
// working key. Writes are to be made while no item is in flight; the block itself does not enforce it.
// A two-entry queue sits between the letter front end and the round engine,
// so input is still taken while the engine runs or the output is stalled.
// The round engine computes one chained keystream round per cycle and takes
// the next queued byte as it writes the result of the last one.
// A stalled result holds the engine in its last round.
// Reset (i_rst_n low, synchronous) clears key registers, working key,
// round state, queue and result valid.
module pc1_stream_decrypt_256_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_high_letter,
    input  logic [7:0]                    i_low_letter,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_plain_byte,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pc1_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);
    import pc1_pkg::*;

    t_cipher_item item;
    logic         pop;

    assign o_cfg_ready = 1'b1;

    pc1_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_high_letter (i_high_letter),
        .i_low_letter  (i_low_letter),
        .i_pop         (pop),
        .o_item        (item)
    );

    pc1_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .o_pop        (pop),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_plain_byte (o_plain_byte)
    );

endmodule

@@ tb/pc1_decrypt_checker.sv @@
// Checker for the PC1 stream decryption block: predicts plaintext and compares results.
module pc1_decrypt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [7:0]                    i_high_letter,
    input  logic [7:0]                    i_low_letter,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [7:0]                    i_plain_byte,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [pc1_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import pc1_pkg::*;

    // Predictor state: key registers, working key and round registers
    logic [63:0] key_reg [KEY_REGS];
    logic [7:0]  work_key [2*ROUNDS];
    logic [15:0] mix_reg;
    logic [15:0] carry_sum;

    // Plaintext bytes still owed by the block, oldest first
    logic [7:0]  plain_due [$];
    int          fails = 0;

    assign o_fail_count = fails;

    // Copy the key registers into the working key, byte 0 most significant
    function automatic void reload_work_key();
        for (int j = 0; j < 2*ROUNDS; j++)
            work_key[j] = key_reg[j/8][56 - 8*(j%8) +: 8];
    endfunction

    // Decrypt one letter pair and advance the keystream state
    function automatic logic [7:0] decrypt_pair(logic [7:0] hi, logic [7:0] lo);
        logic [7:0]  hi_nib;
        logic [7:0]  lo_nib;
        logic [7:0]  cipher;
        logic [7:0]  plain;
        logic [15:0] ks;
        logic [15:0] w;
        logic [15:0] kw;
        logic [15:0] k;
        logic [15:0] kb;
        logic [15:0] cs;
        hi_nib = hi - LETTER_BIAS;
        lo_nib = lo - LETTER_BIAS;
        // letters outside the alphabet simply wrap
        cipher = {hi_nib[3:0], 4'h0} + lo_nib;
        ks = '0;
        w  = '0;
        for (int r = 0; r < ROUNDS; r++) begin
            kw = {work_key[2*r], work_key[2*r+1]};
            k  = (r == 0) ? kw : (w ^ kw);
            kb = k * MUL_B;
            cs = 16'(carry_sum + 16'(r)) * MUL_A + kb + mix_reg;
            mix_reg   = kb;
            carry_sum = cs;
            w  = k * MUL_A + 16'd1;
            ks = ks ^ w ^ cs;
        end
        plain = cipher ^ ks[15:8] ^ ks[7:0];
        // plaintext feeds back into every key byte
        for (int j = 0; j < 2*ROUNDS; j++)
            work_key[j] = work_key[j] ^ plain;
        return plain;
    endfunction

    initial o_pending = 0;

    // Track handshakes at the rising edge
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_REGS; i++)
                key_reg[i] = '0;
            reload_work_key();
            mix_reg   = '0;
            carry_sum = '0;
            plain_due.delete();
        end else begin
            // key write reloads the working key, round state kept
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < KEY_REGS) begin
                key_reg[i_cfg_index[1:0]] = i_cfg_data;
                reload_work_key();
            end
            if (i_in_valid && !i_in_stall)
                plain_due.push_back(decrypt_pair(i_high_letter, i_low_letter));
            if (i_out_valid && !i_out_stall) begin
                if (plain_due.size() == 0) begin
                    $display("%0t: unexpected plain_byte: expected none, got %02h",
                             $time, i_plain_byte);
                    fails++;
                end else begin
                    want = plain_due.pop_front();
                    if (i_plain_byte !== want) begin
                        $display("%0t: plain_byte mismatch: expected %02h, got %02h",
                                 $time, want, i_plain_byte);
                        fails++;
                    end
                end
            end
        end
        o_pending = plain_due.size();
    end

endmodule

@@ tb/pc1_stream_decrypt_256_unit_test.sv @@
// Stimulus and verdict for the PC1 stream decryption block.
module pc1_stream_decrypt_256_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pc1_pkg::*;

    // Register indexes of the config channel
    localparam logic [CFG_IDX_W-1:0] KEY_REG_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] KEY_REG_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] KEY_REG_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] KEY_REG_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] KEY_REG_NONE = 3'd6;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 217;

    // Letter pairs for the directed part: extremes, alphabet ends, wrap cases
    localparam logic [15:0] EDGE_PAIRS [16] = '{
        16'h0000, 16'hffff, 16'h00ff, 16'hff00,
        16'h2525, 16'h3434, 16'h2534, 16'h3425,
        16'h2435, 16'h3524, 16'h807f, 16'h7f80,
        16'haa55, 16'h55aa, 16'h617a, 16'h2626
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [7:0]           i_high_letter = '0;
    logic [7:0]           i_low_letter = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [7:0]           o_plain_byte;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;

    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    pc1_stream_decrypt_256_unit u_top (.*);

    pc1_decrypt_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_high_letter (i_high_letter),
        .i_low_letter  (i_low_letter),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_plain_byte  (o_plain_byte),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Random back-pressure on the result channel
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Mostly letters of the alphabet, some anywhere in the byte range
    function automatic logic [7:0] rand_letter();
        if ($urandom_range(99) < 70)
            return 8'(LETTER_BIAS + 8'($urandom_range(15)));
        return 8'($urandom_range(255));
    endfunction

    // One key write; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Send one item after a random idle gap
    task automatic send_pair(input logic [7:0] hi, input logic [7:0] lo);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 200)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_high_letter <= hi;
        i_low_letter  <= lo;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Hold off input until every owed byte has come out
    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // Key setting for each phase, extremes first
    task automatic load_key(input int phase);
        case (phase)
            0: begin
                write_reg(KEY_REG_0, '0);
                write_reg(KEY_REG_1, '0);
                write_reg(KEY_REG_2, '0);
                write_reg(KEY_REG_3, '0);
                write_reg(KEY_REG_NONE, rand_key());
            end
            1: begin
                write_reg(KEY_REG_0, '1);
                write_reg(KEY_REG_1, '1);
                write_reg(KEY_REG_2, '1);
                write_reg(KEY_REG_3, '1);
            end
            2: begin
                write_reg(KEY_REG_0, "abcdefgh");
                write_reg(KEY_REG_1, "ijklmnop");
                write_reg(KEY_REG_2, "qrstuvwx");
                write_reg(KEY_REG_3, {"yz01234", 8'h00});
            end
            4: begin
                write_reg(KEY_REG_2, rand_key());
            end
            5: begin
                write_reg(KEY_REG_0, 64'h00ff_00ff_00ff_00ff);
                write_reg(KEY_REG_1, 64'hff00_ff00_ff00_ff00);
                write_reg(KEY_REG_2, 64'haa55_aa55_aa55_aa55);
                write_reg(KEY_REG_3, 64'h0123_4567_89ab_cdef);
            end
            7: begin
                write_reg(KEY_REG_1, rand_key());
                write_reg(KEY_REG_NONE, '1);
            end
            default: begin
                write_reg(KEY_REG_0, rand_key());
                write_reg(KEY_REG_1, rand_key());
                write_reg(KEY_REG_2, rand_key());
                write_reg(KEY_REG_3, rand_key());
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // Main sequence
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed pairs on the reset key
        foreach (EDGE_PAIRS[i])
            send_pair(EDGE_PAIRS[i][15:8], EDGE_PAIRS[i][7:0]);

        for (int p = 0; p < PHASES; p++) begin
            drain(4);
            load_key(p);
            @(negedge i_clk);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_pair(rand_letter(), rand_letter());
        end

        drain(40);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Run limit
    initial begin
        #(12_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
